>>> rtl/sobel_gradient_with_direction_unit_defines.svh
// ----------------------------------------------------------------------------
// Sobel gradient unit: assertion macros
// Concurrent assertion wrappers used by the top-level RTL file; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_WITH_DIRECTION_UNIT_DEFINES_SVH
`define SOBEL_GRADIENT_WITH_DIRECTION_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SGD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sobel gradient unit: assertion failed");
`define SGD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sobel gradient unit: assertion failed");
`else
`define SGD_ASSERT(label, clk, rst, prop)
`define SGD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/sgd_pkg.sv
// ----------------------------------------------------------------------------
// Sobel gradient unit: package
// Field widths, register codes, direction codes and shared types.
// ----------------------------------------------------------------------------
package sgd_pkg;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int BORDER_DEF    = 3;

   // smallest effective width and height
   localparam int MIN_DIM = 3;

   // payload widths
   localparam int PIX_W     = 8;
   localparam int CFG_W     = 11;
   localparam int ROW_W     = 11;
   localparam int COL_OUT_W = 10;
   localparam int MAG_W     = 11;
   localparam int DIR_W     = 2;

   // gradient arithmetic
   localparam int GRAD_W     = 11;            // signed gx, gy
   localparam int ABS_W      = 10;            // |gx|, |gy| up to 1020
   localparam int SQ_W       = 2 * MAG_W - 1; // gx^2 + gy^2 below 2^21
   localparam int TAN_PROD_W = 28;
   localparam int Q16_SHIFT  = 16;

   localparam logic [TAN_PROD_W-1:0] TAN_STEEP_Q16 = 28'd158218;
   localparam logic [TAN_PROD_W-1:0] TAN_DIAG_Q16  = 28'd27146;

   // configuration port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_SEL_BIT = 2;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd570;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_STEEP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_NEG_DIAG = 2'd1;
   localparam logic [DIR_W-1:0] DIR_FLAT     = 2'd2;
   localparam logic [DIR_W-1:0] DIR_POS_DIAG = 2'd3;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] root;
   } sqrt_status_type;

endpackage

>>> rtl/sgd_ram.sv
// ----------------------------------------------------------------------------
// Sobel gradient unit: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sgd_isqrt.sv
// ----------------------------------------------------------------------------
// Sobel gradient unit: integer square root
// Shift-subtract floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sgd_isqrt
   import sgd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] radicand,
   output sqrt_status_type status
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W:0]   res_ff, res_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + (SQ_W+1)'(bit_ff);
      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 1);
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = SQ_W'({1'b0, rem_ff} - trial);
            res_in = (res_ff >> 1) + (SQ_W+1)'(bit_ff);
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // last digit: stop and flag the root
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign status.done = done_ff;
   assign status.root = res_ff[MAG_W-1:0];

endmodule

>>> rtl/sobel_gradient_with_direction_unit.sv
// An accepted pixel is read in ST_READ; an interior centre then passes ST_GRAD,
// ST_SQ, ST_SQRT (the 11-step shift-subtract square root) and ST_DONE, a border
// centre goes straight to ST_DONE, and a pixel without a full window gives no
// result. A new pixel is taken only in ST_IDLE, once the last one is through.
// Reset clears the state, position counters, window, geometry and rsp_valid;
// the two line memories have no reset and feed results only from row 2 on.
// ----------------------------------------------------------------------------
// Sobel gradient unit: top level
// Streams raster pixels through two line memories and a 3x3 window; gives the Sobel
// magnitude and quantized direction per interior centre, zero and flat at the border.
// ----------------------------------------------------------------------------
`include "sobel_gradient_with_direction_unit_defines.svh"

module sobel_gradient_with_direction_unit
   import sgd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int BORDER    = BORDER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel,
   input  logic                  req_frame_start,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MAG_W-1:0]      rsp_magnitude,
   output logic [DIR_W-1:0]      rsp_direction,
   output logic [COL_OUT_W-1:0]  rsp_centre_col,
   output logic [ROW_W-1:0]      rsp_centre_row,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_GRAD = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // configuration
   logic [CFG_W-1:0] image_width_ff, image_width_in;
   logic [CFG_W-1:0] image_height_ff, image_height_in;
   logic             csr_write;
   logic [CW:0]      eff_w;
   logic [ROW_W-1:0] eff_h;

   // control
   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             req_accept;

   // transaction in process
   logic [PIX_W-1:0] px_ff, px_in;
   logic [CW-1:0]    c_ff, c_in;
   logic [ROW_W-1:0] r_ff, r_in;
   logic [CW-1:0]    cx_ff, cx_in;
   logic [ROW_W-1:0] cy_ff, cy_in;
   logic [ABS_W-1:0] ax_ff, ax_in;
   logic [ABS_W-1:0] ay_ff, ay_in;
   logic             opp_ff, opp_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [DIR_W-1:0] dir_ff, dir_in;
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]     rsp_magnitude_ff, rsp_magnitude_in;
   logic [DIR_W-1:0]     rsp_direction_ff, rsp_direction_in;
   logic [COL_OUT_W-1:0] rsp_centre_col_ff, rsp_centre_col_in;
   logic [ROW_W-1:0]     rsp_centre_row_ff, rsp_centre_row_in;

   // position logic
   logic [CW-1:0]    col_base, c_pos, col_next;
   logic [ROW_W-1:0] row_base, r_pos, row_next;
   logic [ROW_W:0]   r_step, r_adv;
   logic [CW:0]      c_adv;

   // window, gradient and direction logic
   logic [PIX_W-1:0]         line_top, line_mid;
   logic [CW-1:0]            cx_c;
   logic [ROW_W-1:0]         cy_c;
   logic                     has_window, border;
   logic [ABS_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0] gx, gy;
   logic [2*ABS_W-1:0]       sq_x, sq_y;
   logic [TAN_PROD_W-1:0]    a_q16, b_steep, b_diag;
   logic [DIR_W-1:0]         dir_c;
   logic                     sqrt_start;
   logic [SQ_W-1:0]          sqrt_radicand;
   sqrt_status_type          sq_stat;
   logic                     out_free;
   logic                     ram_wr_en;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write) begin
         case (csr_paddr[CSR_SEL_BIT])
            REG_IMAGE_WIDTH:  image_width_in  = csr_pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: image_height_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_SEL_BIT])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(image_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamp geometry to the supported range
   always_comb begin
      if (32'(image_width_ff) >= 32'(MAX_WIDTH)) begin
         eff_w = (CW+1)'(MAX_WIDTH);
      end else if (32'(image_width_ff) < 32'(MIN_DIM)) begin
         eff_w = (CW+1)'(MIN_DIM);
      end else begin
         eff_w = (CW+1)'(image_width_ff);
      end
      if (image_height_ff < CFG_W'(MIN_DIM)) begin
         eff_h = ROW_W'(MIN_DIM);
      end else begin
         eff_h = image_height_ff;
      end
   end

   // ------------------------------------------------------------------------
   // raster position of the incoming pixel and of the one after it
   // ------------------------------------------------------------------------
   always_comb begin
      col_base = req_frame_start ? '0 : col_ff;
      row_base = req_frame_start ? '0 : row_ff;
      // a column left beyond the width after a geometry change opens a new row
      if ({1'b0, col_base} >= eff_w) begin
         c_pos  = '0;
         r_step = {1'b0, row_base} + (ROW_W+1)'(1);
      end else begin
         c_pos  = col_base;
         r_step = {1'b0, row_base};
      end
      r_pos = (r_step >= {1'b0, eff_h}) ? '0 : r_step[ROW_W-1:0];

      c_adv = {1'b0, c_pos} + (CW+1)'(1);
      r_adv = {1'b0, r_pos} + (ROW_W+1)'(1);
      if (c_adv >= eff_w) begin
         col_next = '0;
         row_next = (r_adv >= {1'b0, eff_h}) ? '0 : r_adv[ROW_W-1:0];
      end else begin
         col_next = c_adv[CW-1:0];
         row_next = r_pos;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // line memories: ram_mid holds row r-1, ram_top holds row r-2
   // ------------------------------------------------------------------------
   assign ram_wr_en = (state_ff == ST_READ);

   sgd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_ram_mid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (c_ff),
      .wr_data (px_ff),
      .rd_addr (c_pos),
      .rd_data (line_mid)
   );

   sgd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_ram_top (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (c_ff),
      .wr_data (line_mid),
      .rd_addr (c_pos),
      .rd_data (line_top)
   );

   // ------------------------------------------------------------------------
   // centre position, border test, gradient and sector
   // ------------------------------------------------------------------------
   always_comb begin
      cx_c       = c_ff - CW'(1);
      cy_c       = r_ff - ROW_W'(1);
      has_window = (c_ff >= CW'(2)) && (r_ff >= ROW_W'(2));
      border     = ({1'b0, cx_c} < (CW+1)'(BORDER))
                || ({1'b0, cx_c} >= eff_w - (CW+1)'(BORDER))
                || (cy_c < ROW_W'(BORDER))
                || (cy_c >= eff_h - ROW_W'(BORDER));
   end

   always_comb begin
      gx_pos = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, win_ff[8]};
      gx_neg = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, win_ff[6]};
      gy_pos = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
      gy_neg = {2'b00, win_ff[6]} + {1'b0, win_ff[7], 1'b0} + {2'b00, win_ff[8]};
      gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
   end

   always_comb begin
      sq_x          = ax_ff * ax_ff;
      sq_y          = ay_ff * ay_ff;
      sqrt_radicand = SQ_W'(sq_x) + SQ_W'(sq_y);
      a_q16         = TAN_PROD_W'(ay_ff) << Q16_SHIFT;
      b_steep       = TAN_PROD_W'(ax_ff) * TAN_STEEP_Q16;
      b_diag        = TAN_PROD_W'(ax_ff) * TAN_DIAG_Q16;
      if (ax_ff == '0) begin
         dir_c = DIR_FLAT;
      end else if (a_q16 > b_steep) begin
         dir_c = DIR_STEEP;
      end else if (a_q16 > b_diag) begin
         dir_c = opp_ff ? DIR_NEG_DIAG : DIR_POS_DIAG;
      end else begin
         dir_c = DIR_FLAT;
      end
   end

   assign sqrt_start = (state_ff == ST_SQ);

   sgd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_radicand),
      .status   (sq_stat)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      col_in            = col_ff;
      row_in            = row_ff;
      px_in             = px_ff;
      c_in              = c_ff;
      r_in              = r_ff;
      cx_in             = cx_ff;
      cy_in             = cy_ff;
      ax_in             = ax_ff;
      ay_in             = ay_ff;
      opp_in            = opp_ff;
      mag_in            = mag_ff;
      dir_in            = dir_ff;
      win_in            = win_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_magnitude_in  = rsp_magnitude_ff;
      rsp_direction_in  = rsp_direction_ff;
      rsp_centre_col_in = rsp_centre_col_ff;
      rsp_centre_row_in = rsp_centre_row_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               px_in    = req_pixel;
               c_in     = c_pos;
               r_in     = r_pos;
               col_in   = col_next;
               row_in   = row_next;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // line data arrives; shift the window and write the lines back
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = line_top;
            win_in[3] = win_ff[4];
            win_in[4] = win_ff[5];
            win_in[5] = line_mid;
            win_in[6] = win_ff[7];
            win_in[7] = win_ff[8];
            win_in[8] = px_ff;
            cx_in     = cx_c;
            cy_in     = cy_c;
            if (!has_window) begin
               state_in = ST_IDLE;
            end else if (border) begin
               mag_in   = '0;
               dir_in   = DIR_FLAT;
               state_in = ST_DONE;
            end else begin
               state_in = ST_GRAD;
            end
         end
         ST_GRAD: begin
            ax_in    = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
            ay_in    = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
            opp_in   = gx[GRAD_W-1] ^ gy[GRAD_W-1];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            dir_in   = dir_c;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_stat.done) begin
               mag_in   = sq_stat.root;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_magnitude_in  = mag_ff;
               rsp_direction_in  = dir_ff;
               rsp_centre_col_in = COL_OUT_W'(cx_ff);
               rsp_centre_row_in = cy_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         col_ff          <= '0;
         row_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         rsp_valid_ff    <= rsp_valid_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         win_ff          <= win_in;
      end
      px_ff             <= px_in;
      c_ff              <= c_in;
      r_ff              <= r_in;
      cx_ff             <= cx_in;
      cy_ff             <= cy_in;
      ax_ff             <= ax_in;
      ay_ff             <= ay_in;
      opp_ff            <= opp_in;
      mag_ff            <= mag_in;
      dir_ff            <= dir_in;
      rsp_magnitude_ff  <= rsp_magnitude_in;
      rsp_direction_ff  <= rsp_direction_in;
      rsp_centre_col_ff <= rsp_centre_col_in;
      rsp_centre_row_ff <= rsp_centre_row_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_magnitude_ff;
   assign rsp_direction  = rsp_direction_ff;
   assign rsp_centre_col = rsp_centre_col_ff;
   assign rsp_centre_row = rsp_centre_row_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `SGD_ASSERT(a_zero_mag_is_flat, clock, reset, (rsp_valid_ff && (rsp_magnitude_ff == '0)) |-> (rsp_direction_ff == DIR_FLAT))
   `SGD_ASSERT(a_centre_row_inside, clock, reset, rsp_valid_ff |-> (rsp_centre_row_ff != '0))
   `SGD_ASSERT(a_load_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
   `SGD_ASSERT_ALWAYS(a_root_in_sqrt_state, clock, sq_stat.done |-> (state_ff == ST_SQRT))

endmodule
